@@ rtl/invm_pkg.sv @@
// ----------------------------------------------------------------------------
// invm_pkg
// Shared constants and types for the null-vector-by-minors block.
// ----------------------------------------------------------------------------
package invm_pkg;
  localparam int MaxTerms   = 9;
  localparam int EntryBits  = 8;
  localparam int MaxCols    = MaxTerms - 1;
  localparam int StoreDepth = MaxTerms * MaxCols;
  localparam int TableDepth = 1 << MaxCols;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int TableAw    = MaxCols;
  localparam int ColW       = $clog2(MaxCols);
  localparam int RowW       = 4;
  localparam int CoefW      = 32;

  typedef logic [RowW-1:0]    row_t;
  typedef logic [ColW-1:0]    col_t;
  typedef logic [TableAw-1:0] subset_t;
  typedef logic [StoreAw-1:0] saddr_t;
  typedef logic [CoefW-1:0]   word_t;

  // Result record: coefficient, row index, solvable and last flags.
  typedef struct packed {
    word_t coef;
    row_t  row;
    logic  solv;
    logic  last;
  } res_t;
endpackage

@@ rtl/invm_mat_store.sv @@
// ----------------------------------------------------------------------------
// invm_mat_store
// Matrix entry memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module invm_mat_store (
  input  logic                               clk,
  input  logic                               we,
  input  invm_pkg::saddr_t                   waddr,
  input  logic signed [invm_pkg::EntryBits-1:0] wdata,
  input  invm_pkg::saddr_t                   raddr,
  output logic signed [invm_pkg::EntryBits-1:0] rdata
);
  import invm_pkg::*;

  logic signed [EntryBits-1:0] mem [StoreDepth];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/invm_sub_table.sv @@
// ----------------------------------------------------------------------------
// invm_sub_table
// Subset determinant table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module invm_sub_table (
  input  logic              clk,
  input  logic              we,
  input  invm_pkg::subset_t waddr,
  input  invm_pkg::word_t   wdata,
  input  invm_pkg::subset_t raddr,
  output invm_pkg::word_t   rdata
);
  import invm_pkg::*;

  word_t mem [TableDepth];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/integer_null_vector_by_minors.sv @@
// ----------------------------------------------------------------------------
// integer_null_vector_by_minors
// Loads an N x (N-1) signed matrix and emits the signed minors of each row.
// ----------------------------------------------------------------------------
// One item is taken per cycle while loading; no result appears until the
// last of the N*(N-1) entries. The block then computes each row's minor by
// walking the column subsets of the subset table in increasing order through
// a single 32x32 multiplier fed by the two memories. Each subset is started,
// scans its m = N-1 columns one by one, reads, multiplies and accumulates
// on every set column, and is written back to the table. All N minors are
// done before the first result is offered, unless a minor is zero: then the
// output begins with a single result that is marked not solvable.
// The input is held off from the last entry until the final result of the
// run is accepted. Results then leave one per accepted cycle. Writing the
// size through cfg_we restarts loading.
module integer_null_vector_by_minors (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [invm_pkg::EntryBits-1:0]  in_entry_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [invm_pkg::CoefW-1:0]      out_coefficient,
  output invm_pkg::row_t                         out_term_index,
  output logic                                   out_solvable,
  output logic                                   out_last_result,
  input  logic                                   cfg_we,
  input  logic [3:0]                             cfg_data
);
  import invm_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_SUB  = 8'b0000_0010,
    S_COL  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } st_t;

  st_t     st_r, st_nxt;
  row_t    n_r, n_use;
  row_t    m_use;
  saddr_t  ld_r;
  row_t    skip_r;
  subset_t s_r;
  col_t    col_r;
  word_t   acc_r;
  logic    neg_r;
  word_t   prod_r;
  word_t   cbuf_r [MaxTerms];
  logic    zero_r;
  row_t    zrow_r;
  row_t    oi_r;
  row_t    pc;
  row_t    lrow;
  row_t    row_sel;
  logic    s_single;
  logic    full_s;
  saddr_t  last_ld;

  // Memory ports.
  logic                        ms_we;
  saddr_t                      ms_raddr;
  logic signed [EntryBits-1:0] ms_rdata;
  logic                        st_we;
  subset_t                     st_raddr;
  word_t                       st_wdata;
  word_t                       st_rdata;

  // Clamp the size register.
  always_comb begin
    priority if (n_r < 4'd2) begin
      n_use = 4'd2;
    end else if (n_r > row_t'(MaxTerms)) begin
      n_use = row_t'(MaxTerms);
    end else begin
      n_use = n_r;
    end
  end
  assign m_use   = n_use - 4'd1;
  assign last_ld = saddr_t'(n_use * m_use - 8'd1);

  // Subset bookkeeping: popcount and the expansion row for this subset.
  always_comb begin
    pc = '0;
    for (int b = 0; b < MaxCols; b++) begin
      pc = pc + row_t'(s_r[b]);
    end
    s_single = (pc == 4'd1);
    full_s   = (s_r == subset_t'((9'd1 << m_use) - 9'd1));
    // Logical row index m - pc (rows m-1 for singletons), mapped past skip.
    lrow     = s_single ? m_use - 4'd1 : m_use - pc;
    row_sel  = (lrow >= skip_r) ? lrow + 4'd1 : lrow;
  end

  assign ms_we    = (st_r == S_LOAD) && in_valid;
  assign ms_raddr = saddr_t'(row_sel) * saddr_t'(m_use) + saddr_t'(col_r);
  assign st_raddr = s_r ^ subset_t'(1 << col_r);
  assign st_we    = (st_r == S_WR);
  assign st_wdata = acc_r;

  invm_mat_store u_mat (
    .clk   (clk),
    .we    (ms_we),
    .waddr (ld_r),
    .wdata (in_entry_value),
    .raddr (ms_raddr),
    .rdata (ms_rdata)
  );

  invm_sub_table u_tab (
    .clk   (clk),
    .we    (st_we),
    .waddr (s_r),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign in_ready = (st_r == S_LOAD);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD: if (in_valid && ld_r == last_ld) st_nxt = S_SUB;
      S_SUB:  st_nxt = S_COL;
      S_COL: begin
        priority if (col_r >= col_t'(m_use - 4'd1) && !s_r[col_r]) begin
          st_nxt = S_WR;
        end else if (s_r[col_r]) begin
          st_nxt = S_RD;
        end else begin
          st_nxt = S_COL;
        end
      end
      S_RD:   st_nxt = S_MUL;
      S_MUL:  st_nxt = S_ACC;
      S_ACC:  st_nxt = (col_r == col_t'(m_use - 4'd1)) ? S_WR : S_COL;
      S_WR: begin
        priority if (!full_s) begin
          st_nxt = S_SUB;
        end else if (acc_r == '0 || skip_r == n_use - 4'd1) begin
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_SUB;
        end
      end
      S_OUT:  if (out_ready && (zero_r || oi_r == n_use - 4'd1)) st_nxt = S_LOAD;
      default: st_nxt = S_LOAD;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      n_r  <= 4'd4;
      ld_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        n_r  <= cfg_data;
        ld_r <= '0;
      end else if (ms_we) begin
        ld_r <= (ld_r == last_ld) ? '0 : ld_r + saddr_t'(1);
      end
    end

    unique case (st_r)
      S_LOAD: begin
        skip_r <= '0;
        s_r    <= subset_t'(1);
        zero_r <= 1'b0;
        oi_r   <= '0;
        col_r  <= '0;
      end
      S_SUB: begin
        col_r <= '0;
        acc_r <= '0;
        neg_r <= 1'b0;
      end
      S_COL: if (!s_r[col_r] && col_r < col_t'(m_use - 4'd1)) col_r <= col_r + col_t'(1);
      S_RD:  ;
      S_MUL: prod_r <= word_t'(32'(signed'(ms_rdata)) * st_rdata);
      S_ACC: begin
        // Singleton subsets take the bare entry.
        if (s_single) begin
          acc_r <= word_t'(signed'(ms_rdata));
        end else begin
          acc_r <= neg_r ? acc_r - prod_r : acc_r + prod_r;
        end
        neg_r <= ~neg_r;
        if (col_r != col_t'(m_use - 4'd1)) col_r <= col_r + col_t'(1);
      end
      S_WR: begin
        if (full_s) begin
          cbuf_r[skip_r] <= skip_r[0] ? word_t'(0) - acc_r : acc_r;
          if (acc_r == '0) begin
            zero_r <= 1'b1;
            zrow_r <= skip_r;
          end
          skip_r <= skip_r + 4'd1;
          s_r    <= subset_t'(1);
        end else begin
          s_r <= s_r + subset_t'(1);
        end
      end
      S_OUT: if (out_ready) oi_r <= oi_r + 4'd1;
      default: ;
    endcase
  end

  // Result presentation.
  assign out_valid       = (st_r == S_OUT);
  assign out_coefficient = zero_r ? '0 : cbuf_r[oi_r];
  assign out_term_index  = zero_r ? zrow_r : oi_r;
  assign out_solvable    = ~zero_r;
  assign out_last_result = zero_r || (oi_r == n_use - 4'd1);
endmodule
